@@ rtl/pre_pkg.sv @@
// shared types, constants and helpers for the printable run extractor
// no dependencies; every other file in rtl/ uses it by scoped names
package pre_pkg;

	localparam int RunBufDepth = 32;
	localparam int OffsetW     = 48;
	localparam int MinW        = 6;
	localparam int CntW        = $clog2(RunBufDepth + 1);
	localparam int AddrW       = $clog2(RunBufDepth);

	localparam logic [MinW-1:0] MIN_RESET = MinW'(4);

	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7e;
	localparam logic [7:0] BYTE_TAB = 8'h09;

	localparam logic KIND_TEXT   = 1'b0;
	localparam logic KIND_MARKER = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_source;
	} item_t;

	typedef struct packed {
		logic               record_kind;
		logic [7:0]         text_byte;
		logic [OffsetW-1:0] start_offset;
		logic               run_start;
		logic               last_result;
	} result_t;

	// minimum clamped to 1..RunBufDepth
	function automatic logic [CntW-1:0] eff_min(input logic [MinW-1:0] m);
		logic [MinW+CntW-1:0] m_ext;
		m_ext = {{CntW{1'b0}}, m};
		if (m == '0)
			return CntW'(1);
		else if (m_ext > (MinW+CntW)'(RunBufDepth))
			return CntW'(RunBufDepth);
		else
			return CntW'(m_ext);
	endfunction

endpackage

@@ rtl/pre_run_ram.sv @@
// run buffer: single write port, single read port, registered read data
// depends on pre_pkg for depth and address width
module pre_run_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [pre_pkg::AddrW-1:0]  waddr,
	input  logic [7:0]                 wdata,
	input  logic                       re,
	input  logic [pre_pkg::AddrW-1:0]  raddr,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [pre_pkg::RunBufDepth];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re)
			rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

@@ rtl/pre_out_reg.sv @@
// output register of the result channel, decouples the scan from a stalled sink
// depends on pre_pkg for the result type
module pre_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  pre_pkg::result_t d,
	output logic             ready,
	output logic             result_valid,
	input  logic             result_stall,
	output pre_pkg::result_t result
);

	logic             valid_q;
	pre_pkg::result_t data_q;

	assign ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load)
			data_q <= d;
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

@@ rtl/printable_run_extractor_unit.sv @@
// printable run extractor: each item is accepted, then evaluated, and the next item is
// taken only once the unit is idle again; the evaluate step loads its result into the output register
// when a run reaches the minimum, its n buffered bytes leave one by one, each with
// one buffer read and then one output load, before the next item is taken;
// reset clears control state and the offsets and sets the minimum to 4;
// the run buffer is not cleared, only bytes written in the current run are read
module printable_run_extractor_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  pre_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output pre_pkg::result_t            result,
	input  logic                        cfg_we,
	input  logic [pre_pkg::MinW-1:0]    cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_EVAL     = 4'b0010,
		ST_BURST_RD = 4'b0100,
		ST_BURST_WR = 4'b1000
	} state_t;

	state_t                          state_q, state_d;
	pre_pkg::item_t                  item_q;
	logic [pre_pkg::MinW-1:0]        min_q;
	logic [pre_pkg::CntW-1:0]        count_q, count_d;
	logic [pre_pkg::CntW-1:0]        idx_q, idx_d;
	logic                            emitting_q, emitting_d;
	logic [pre_pkg::OffsetW-1:0]     start_off_q, start_off_d;
	logic [pre_pkg::OffsetW-1:0]     src_off_q, src_off_d;
	logic [pre_pkg::OffsetW-1:0]     src_off_inc;
	logic [pre_pkg::CntW-1:0]        new_count;
	logic                            printable;
	logic                            ram_we, ram_re;
	logic [7:0]                      ram_rdata;
	logic                            out_ready, out_load;
	pre_pkg::result_t                out_d;
	logic                            accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	assign printable = (item_q.data_byte inside {[pre_pkg::PRINT_LO:pre_pkg::PRINT_HI],
		pre_pkg::BYTE_TAB});

	// offset saturates at all ones
	assign src_off_inc = (&src_off_q) ? src_off_q : src_off_q + pre_pkg::OffsetW'(1);

	assign new_count = (count_q < pre_pkg::CntW'(pre_pkg::RunBufDepth)) ?
		count_q + pre_pkg::CntW'(1) : count_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		emitting_d  = emitting_q;
		start_off_d = start_off_q;
		src_off_d   = src_off_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		out_load    = 1'b0;
		out_d       = '{record_kind: pre_pkg::KIND_MARKER, text_byte: 8'h00,
			start_offset: start_off_q, run_start: 1'b0, last_result: 1'b1};

		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (item_q.end_of_source || !printable) begin
					// close the run; a reported run gets its marker
					if (!emitting_q || out_ready) begin
						out_load   = emitting_q;
						count_d    = '0;
						emitting_d = 1'b0;
						src_off_d  = item_q.end_of_source ? '0 : src_off_inc;
						state_d    = ST_IDLE;
					end
				end else if (emitting_q) begin
					out_d.record_kind = pre_pkg::KIND_TEXT;
					out_d.text_byte   = item_q.data_byte;
					if (out_ready) begin
						out_load  = 1'b1;
						src_off_d = src_off_inc;
						state_d   = ST_IDLE;
					end
				end else begin
					if (count_q == '0)
						start_off_d = src_off_q;
					ram_we    = (count_q < pre_pkg::CntW'(pre_pkg::RunBufDepth));
					count_d   = new_count;
					src_off_d = src_off_inc;
					idx_d     = '0;
					if (new_count >= pre_pkg::eff_min(min_q))
						state_d = ST_BURST_RD;
					else
						state_d = ST_IDLE;
				end
			end
			ST_BURST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_BURST_WR;
			end
			ST_BURST_WR: begin
				out_d.record_kind = pre_pkg::KIND_TEXT;
				out_d.text_byte   = ram_rdata;
				out_d.run_start   = (idx_q == '0);
				out_d.last_result = (idx_q + pre_pkg::CntW'(1) == count_q);
				if (out_ready) begin
					out_load = 1'b1;
					if (out_d.last_result) begin
						count_d    = '0;
						emitting_d = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						idx_d   = idx_q + pre_pkg::CntW'(1);
						state_d = ST_BURST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= pre_pkg::MIN_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			emitting_q  <= 1'b0;
			start_off_q <= '0;
			src_off_q   <= '0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			emitting_q  <= emitting_d;
			start_off_q <= start_off_d;
			src_off_q   <= src_off_d;
			if (cfg_we)
				min_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= item;
	end

	pre_run_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[pre_pkg::AddrW-1:0]),
		.wdata (item_q.data_byte),
		.re    (ram_re),
		.raddr (idx_q[pre_pkg::AddrW-1:0]),
		.rdata (ram_rdata)
	);

	pre_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (out_load),
		.d            (out_d),
		.ready        (out_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
